// File: rtl/core/fmprc_pkg.sv
// ----------------------------------------------------------------------------
// fmprc_pkg
// Shared types, codes and helpers of the first-match packet rule classifier.
// ----------------------------------------------------------------------------
package fmprc_pkg;

  localparam int RULE_SLOTS = 64;
  localparam int SLOT_W     = $clog2(RULE_SLOTS);
  localparam int COUNT_W    = $clog2(RULE_SLOTS + 1);

  localparam logic [1:0] MODE_APPEND   = 2'd0;
  localparam logic [1:0] MODE_CLASSIFY = 2'd1;
  localparam logic [1:0] MODE_CLEAR    = 2'd2;

  localparam logic [1:0] ST_MATCH   = 2'd0;
  localparam logic [1:0] ST_NOMATCH = 2'd1;
  localparam logic [1:0] ST_DONE    = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [2:0] PROTO_ANY   = 3'd0;
  localparam logic [2:0] PROTO_ICMP  = 3'd1;
  localparam logic [2:0] PROTO_TCP   = 3'd2;
  localparam logic [2:0] PROTO_UDP   = 3'd3;
  localparam logic [2:0] PROTO_OTHER = 3'd4;

  localparam logic [7:0] IPPROTO_ICMP = 8'd1;
  localparam logic [7:0] IPPROTO_TCP  = 8'd6;
  localparam logic [7:0] IPPROTO_UDP  = 8'd17;

  localparam logic [1:0]  DIR_ANY       = 2'd2;
  localparam logic [1:0]  ACK_ANY       = 2'd2;
  localparam logic [15:0] PORT_WILD     = 16'd0;
  localparam logic [15:0] PORT_AT_LEAST = 16'd1023;
  localparam logic [5:0]  PREFIX_MAX    = 6'd32;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [5:0]  src_prefix_len;
    logic [5:0]  dst_prefix_len;
    logic [7:0]  ip_protocol;
    logic [2:0]  rule_protocol;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [1:0]  direction;
    logic [1:0]  ack_code;
    logic        rule_action;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] rule_index;
    logic       verdict;
  } rsp_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [2:0]  protocol;
    logic [1:0]  direction;
    logic [1:0]  ack;
    logic        action;
    logic [5:0]  src_len;
    logic [5:0]  dst_len;
  } rule_t;

  function automatic logic [5:0] prefix_sat(input logic [5:0] len);
    prefix_sat = (len > PREFIX_MAX) ? PREFIX_MAX : len;
  endfunction

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [5:0] n;
    n = prefix_sat(len);
    if (n == 6'd0) begin
      prefix_mask = 32'h0;
    end else begin
      prefix_mask = 32'hFFFF_FFFF << (PREFIX_MAX - n);
    end
  endfunction

endpackage

// File: rtl/core/first_match_packet_rule_classifier.sv
// Append, clear, unknown mode and lookup on an empty table go straight to the emit state.
// Classify: rules are read in order and compared until the first hit or the last rule, then emitted.
// One transaction at a time: req_stall stays high until the response is loaded.
// A new transaction is taken only after the last response is loaded; the scan reads one rule a cycle.
// Reset (rst, synchronous): rule count zero, no response pending; table contents kept.
// ----------------------------------------------------------------------------
// first_match_packet_rule_classifier
// Ordered rule table with first-match classification of packet headers.
// ----------------------------------------------------------------------------
module first_match_packet_rule_classifier
  import fmprc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] issue_idx;
  logic [COUNT_W-1:0] issue_idx_next;
  logic               chk_valid;
  logic               chk_valid_next;
  logic [SLOT_W-1:0]  chk_idx;
  req_t               pkt;
  rsp_t               res;
  rsp_t               res_next;
  rule_t              wr_rule;
  rule_t              rd_rule;
  logic               wr_en;
  logic               hit;
  logic               accept;
  logic               scan_done;
  logic               emit_load;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign wr_en     = accept && (req.mode == MODE_APPEND) && (count < COUNT_W'(RULE_SLOTS));
  assign emit_load = (state == S_EMIT) && (!rsp_valid || !rsp_stall);

  always_comb begin
    wr_rule.src_len   = prefix_sat(req.src_prefix_len);
    wr_rule.dst_len   = prefix_sat(req.dst_prefix_len);
    wr_rule.src_addr  = req.src_addr & prefix_mask(req.src_prefix_len);
    wr_rule.dst_addr  = req.dst_addr & prefix_mask(req.dst_prefix_len);
    wr_rule.sport     = req.sport;
    wr_rule.dport     = req.dport;
    wr_rule.protocol  = req.rule_protocol;
    wr_rule.direction = req.direction;
    wr_rule.ack       = req.ack_code;
    wr_rule.action    = req.rule_action;
  end

  fmprc_ram #(
    .WIDTH ($bits(rule_t)),
    .DEPTH (RULE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[SLOT_W-1:0]),
    .wdata (wr_rule),
    .raddr (issue_idx[SLOT_W-1:0]),
    .rdata (rd_rule)
  );

  fmprc_match u_match (
    .pkt  (pkt),
    .rule (rd_rule),
    .hit  (hit)
  );

  assign scan_done = (state == S_SCAN) && chk_valid &&
                     (hit || ({1'b0, chk_idx} == COUNT_W'(count - 1'b1)));

  always_comb begin
    state_next     = state;
    count_next     = count;
    issue_idx_next = issue_idx;
    res_next       = res;
    chk_valid_next = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_next       = '{status: ST_NOMATCH, rule_index: 6'd0, verdict: 1'b0};
          issue_idx_next = '0;
          state_next     = S_EMIT;
          case (req.mode)
            MODE_APPEND: begin
              if (wr_en) begin
                count_next      = count + 1'b1;
                res_next.status = ST_DONE;
              end else begin
                res_next.status = ST_FULL;
              end
            end
            MODE_CLEAR: begin
              count_next      = '0;
              res_next.status = ST_DONE;
            end
            MODE_CLASSIFY: begin
              if (count != '0) begin
                state_next = S_SCAN;
              end
            end
            default: begin
              res_next.status = ST_NOMATCH;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_EMIT;
          if (hit) begin
            res_next.status     = ST_MATCH;
            res_next.rule_index = 6'(chk_idx);
            res_next.verdict    = rd_rule.action;
          end
        end else if (issue_idx < count) begin
          chk_valid_next = 1'b1;
          issue_idx_next = issue_idx + 1'b1;
        end
      end
      S_EMIT: begin
        if (emit_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      chk_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      chk_valid <= chk_valid_next;
      rsp_valid <= emit_load || (rsp_valid && rsp_stall);
    end
  end

  always_ff @(posedge clk) begin
    issue_idx <= issue_idx_next;
    chk_idx   <= issue_idx[SLOT_W-1:0];
    res       <= res_next;
    if (accept) begin
      pkt <= req;
    end
    if (emit_load) begin
      rsp <= res;
    end
  end

endmodule

// File: rtl/core/fmprc_ram.sv
// ----------------------------------------------------------------------------
// fmprc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fmprc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/fmprc_match.sv
// ----------------------------------------------------------------------------
// fmprc_match
// Compare unit: tests one stored rule against the held packet header.
// ----------------------------------------------------------------------------
module fmprc_match
  import fmprc_pkg::*;
(
  input  req_t  pkt,
  input  rule_t rule,
  output logic  hit
);

  logic [2:0] pclass;
  logic       addr_ok;
  logic       dir_ok;
  logic       proto_ok;
  logic       sport_ok;
  logic       dport_ok;
  logic       ack_ok;
  logic       ported;

  always_comb begin
    case (pkt.ip_protocol)
      IPPROTO_ICMP: pclass = PROTO_ICMP;
      IPPROTO_TCP:  pclass = PROTO_TCP;
      IPPROTO_UDP:  pclass = PROTO_UDP;
      default:      pclass = PROTO_OTHER;
    endcase
  end

  assign addr_ok  = ((pkt.src_addr & prefix_mask(rule.src_len)) == rule.src_addr) &&
                    ((pkt.dst_addr & prefix_mask(rule.dst_len)) == rule.dst_addr);
  assign dir_ok   = (pkt.direction == rule.direction) || (rule.direction == DIR_ANY) ||
                    (pkt.direction == DIR_ANY);
  assign proto_ok = (rule.protocol == PROTO_ANY) || (rule.protocol == pclass);
  assign sport_ok = (rule.sport == PORT_WILD) || (rule.sport == pkt.sport) ||
                    ((rule.sport == PORT_AT_LEAST) && (pkt.sport >= PORT_AT_LEAST));
  assign dport_ok = (rule.dport == PORT_WILD) || (rule.dport == pkt.dport) ||
                    ((rule.dport == PORT_AT_LEAST) && (pkt.dport >= PORT_AT_LEAST));
  assign ported   = (pclass == PROTO_TCP) || (pclass == PROTO_UDP);
  assign ack_ok   = (pclass != PROTO_TCP) || (rule.ack >= ACK_ANY) || (rule.ack == pkt.ack_code);

  assign hit = addr_ok && dir_ok && proto_ok && (!ported || (sport_ok && dport_ok)) && ack_ok;

endmodule

// File: rtl/core/fmprc_checker.sv
// ----------------------------------------------------------------------------
// fmprc_checker
// Port-level checks of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module fmprc_checker
  import fmprc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while a transaction is in progress");

  a_no_early_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> !$rose(rsp_valid))
    else $error("response appeared without processing time");

  a_clean_miss: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_MATCH) |-> (rsp.rule_index == 6'd0) && !rsp.verdict)
    else $error("index or verdict set without a match");

endmodule

bind first_match_packet_rule_classifier fmprc_checker u_fmprc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
